FILE: sv/crc16_frame_checker_assert.svh
// ----------------------------------------------------------------------------
// crc16_frame_checker_assert.svh - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_CHECKER_ASSERT_SVH
`define CRC16_FRAME_CHECKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CRCFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CRCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/crcfc_pkg.sv
// ----------------------------------------------------------------------------
// crcfc_pkg - shared types, codes and CRC function
// Constants and structs used by the frame checker top level and its tracker.
// ----------------------------------------------------------------------------
package crcfc_pkg;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Byte counter saturates here
  localparam logic [16:0] INDEX_MAX = 17'h1FFFF;

  // Frame layout offsets
  localparam logic [16:0] IDX_START0 = 17'd0;
  localparam logic [16:0] IDX_START1 = 17'd1;
  localparam logic [16:0] IDX_SEQ    = 17'd2;
  localparam logic [16:0] IDX_MSGID  = 17'd3;
  localparam logic [16:0] IDX_LEN_LO = 17'd4;
  localparam logic [16:0] IDX_LEN_HI = 17'd5;
  localparam logic [16:0] IDX_PAYLD  = 17'd6;
  localparam logic [16:0] IDX_CHECK  = 17'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_START_FIRST  = 2'd0;
  localparam logic [1:0] REG_START_SECOND = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_LIM  = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  START_FIRST_RST  = 8'hA5;
  localparam logic [7:0]  START_SECOND_RST = 8'h5A;
  localparam logic [15:0] PAYLOAD_LIM_RST  = 16'd1024;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK         = 2'd0;
  localparam logic [1:0] VERDICT_INCOMPLETE = 2'd1;
  localparam logic [1:0] VERDICT_CORRUPTED  = 2'd2;
  localparam logic [1:0] VERDICT_TOO_LONG   = 2'd3;

  // One input beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } beat_t;

  // Current configuration
  typedef struct packed {
    logic [7:0]  start_first;
    logic [7:0]  start_second;
    logic [15:0] payload_limit;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  verdict;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_msg_id;
    logic [15:0] frame_length;
  } result_t;

  // Byte-wide CRC update, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/crc16_frame_checker.sv
// ----------------------------------------------------------------------------
// crc16_frame_checker - start/length/CRC-16 frame checker
//
//   Channel   Handshake               Payload
//   in        in_valid / in_ready     rx_byte, buffer_end
//   out       out_valid / out_ready   result_kind, payload_byte, verdict,
//                                     frame_seq, frame_msg_id, frame_length
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per clock while the output is not stalled; out_valid for a result
// rises when its byte moves on from the input register. The byte-wide CRC
// update between the input and output registers sets the per-cycle work.
// Reset (rst, synchronous) restores the register defaults and the tracker.
// A stalled output holds its beat; the input register keeps accepting while
// its byte yields no result or the output slot is free or being drained.
// ----------------------------------------------------------------------------
`include "crc16_frame_checker_assert.svh"

module crc16_frame_checker (
  input  logic        clk,
  input  logic        rst,
  // Byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        buffer_end,
  // Result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [1:0]  verdict,
  output logic [7:0]  frame_seq,
  output logic [7:0]  frame_msg_id,
  output logic [15:0] frame_length,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  crcfc_pkg::cfg_t    cfg;
  crcfc_pkg::beat_t   s1_beat;
  logic               s1_valid;
  logic               s1_advance;
  logic               res_valid;
  crcfc_pkg::result_t res;
  crcfc_pkg::result_t out_beat;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_first   <= crcfc_pkg::START_FIRST_RST;
      cfg.start_second  <= crcfc_pkg::START_SECOND_RST;
      cfg.payload_limit <= crcfc_pkg::PAYLOAD_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        crcfc_pkg::REG_START_FIRST:  cfg.start_first   <= cfg_data[7:0];
        crcfc_pkg::REG_START_SECOND: cfg.start_second  <= cfg_data[7:0];
        crcfc_pkg::REG_PAYLOAD_LIM:  cfg.payload_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_advance = s1_valid && (!res_valid || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat.rx_byte    <= rx_byte;
      s1_beat.buffer_end <= buffer_end;
    end
  end

  // Frame tracking
  crcfc_track u_track (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_advance),
    .beat      (s1_beat),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && res_valid) begin
      out_beat <= res;
    end
  end

  assign result_kind  = out_beat.result_kind;
  assign payload_byte = out_beat.payload_byte;
  assign verdict      = out_beat.verdict;
  assign frame_seq    = out_beat.frame_seq;
  assign frame_msg_id = out_beat.frame_msg_id;
  assign frame_length = out_beat.frame_length;

  // Checks
  `CRCFC_ASSERT_NOW(a_payload_clean,
    out_valid && result_kind == crcfc_pkg::KIND_PAYLOAD,
    verdict == crcfc_pkg::VERDICT_OK && frame_length == 16'd0,
    "payload beat carries verdict fields")
  `CRCFC_ASSERT_NOW(a_fail_fields_zero,
    out_valid && result_kind == crcfc_pkg::KIND_VERDICT && verdict != crcfc_pkg::VERDICT_OK,
    frame_seq == 8'd0 && frame_msg_id == 8'd0 && frame_length == 16'd0,
    "failed verdict carries frame fields")
  `CRCFC_ASSERT_NEXT(a_s1_hold,
    s1_valid && !s1_advance,
    s1_valid && $stable(s1_beat),
    "held input beat lost or changed")
  `CRCFC_ASSERT_NOW(a_stall_cause,
    !in_ready,
    s1_valid && res_valid && out_valid && !out_ready,
    "input stalled without a blocked result")

endmodule

FILE: sv/crcfc_track.sv
// ----------------------------------------------------------------------------
// crcfc_track - per-buffer frame tracker
// Holds header fields, running CRC and byte position for the current buffer
// and decides, for each beat, whether it yields a payload byte or a verdict.
// ----------------------------------------------------------------------------
module crcfc_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  crcfc_pkg::beat_t  beat,
  input  crcfc_pkg::cfg_t   cfg,
  output logic              res_valid,
  output crcfc_pkg::result_t res
);

  // Buffer state
  logic [16:0] byte_index;
  logic [15:0] crc_acc;
  logic        start_mismatch;
  logic [7:0]  held_seq;
  logic [7:0]  held_msg_id;
  logic [15:0] held_length;
  logic [7:0]  crc_low_byte;
  logic        verdict_given;

  logic [16:0] byte_index_next;
  logic [15:0] crc_acc_next;
  logic        start_mismatch_next;
  logic [7:0]  held_seq_next;
  logic [7:0]  held_msg_id_next;
  logic [15:0] held_length_next;
  logic [7:0]  crc_low_byte_next;
  logic        verdict_given_next;
  logic        restart;

  logic [7:0]  b;
  logic [16:0] len17;
  logic [16:0] crc_end;
  logic [16:0] frame_end;
  logic        have_verdict;
  logic [1:0]  vcode;
  logic        pass_payload;
  logic        over_limit;

  assign b     = beat.rx_byte;
  assign len17 = {1'b0, held_length_next};
  assign crc_end   = len17 + crcfc_pkg::IDX_PAYLD;
  assign frame_end = len17 + crcfc_pkg::IDX_CHECK;
  assign over_limit = held_length_next > cfg.payload_limit;

  // Header capture and CRC accumulate
  always_comb begin
    start_mismatch_next = start_mismatch;
    held_seq_next       = held_seq;
    held_msg_id_next    = held_msg_id;
    held_length_next    = held_length;
    if (byte_index == crcfc_pkg::IDX_START0 && b != cfg.start_first) begin
      start_mismatch_next = 1'b1;
    end
    if (byte_index == crcfc_pkg::IDX_START1 && b != cfg.start_second) begin
      start_mismatch_next = 1'b1;
    end
    if (byte_index == crcfc_pkg::IDX_SEQ) begin
      held_seq_next = b;
    end
    if (byte_index == crcfc_pkg::IDX_MSGID) begin
      held_msg_id_next = b;
    end
    if (byte_index == crcfc_pkg::IDX_LEN_LO) begin
      held_length_next = {8'h00, b};
    end
    if (byte_index == crcfc_pkg::IDX_LEN_HI) begin
      held_length_next = {b, held_length[7:0]};
    end
  end

  // crc_end is never below the payload offset, so this also covers the header
  assign crc_acc_next = (byte_index < crc_end) ? crcfc_pkg::crc16_byte(crc_acc, b)
                                               : crc_acc;
  assign crc_low_byte_next = (byte_index == crc_end) ? b : crc_low_byte;

  // Verdict decision, early checks first
  always_comb begin
    have_verdict = 1'b1;
    vcode        = crcfc_pkg::VERDICT_OK;
    priority if (byte_index == crcfc_pkg::IDX_CHECK && start_mismatch_next) begin
      vcode = crcfc_pkg::VERDICT_CORRUPTED;
    end else if (byte_index == crcfc_pkg::IDX_CHECK && over_limit) begin
      vcode = crcfc_pkg::VERDICT_TOO_LONG;
    end else if (byte_index == frame_end) begin
      vcode = (crc_acc_next == {b, crc_low_byte_next}) ? crcfc_pkg::VERDICT_OK
                                                       : crcfc_pkg::VERDICT_CORRUPTED;
    end else if (beat.buffer_end) begin
      vcode = crcfc_pkg::VERDICT_INCOMPLETE;
    end else begin
      have_verdict = 1'b0;
    end
  end

  assign pass_payload = (byte_index >= crcfc_pkg::IDX_PAYLD) && (byte_index < crc_end)
                        && !start_mismatch_next && !over_limit;

  // Result and bookkeeping for this beat
  always_comb begin
    res                = '0;
    res_valid          = 1'b0;
    restart            = 1'b0;
    verdict_given_next = verdict_given;
    byte_index_next    = byte_index;
    if (verdict_given) begin
      restart = beat.buffer_end;
    end else if (have_verdict) begin
      res_valid           = 1'b1;
      res.result_kind     = crcfc_pkg::KIND_VERDICT;
      res.verdict         = vcode;
      if (vcode == crcfc_pkg::VERDICT_OK) begin
        res.frame_seq    = held_seq_next;
        res.frame_msg_id = held_msg_id_next;
        res.frame_length = held_length_next;
      end
      restart            = beat.buffer_end;
      verdict_given_next = 1'b1;
    end else begin
      if (byte_index < crcfc_pkg::INDEX_MAX) begin
        byte_index_next = byte_index + 17'd1;
      end
      if (pass_payload) begin
        res_valid        = 1'b1;
        res.result_kind  = crcfc_pkg::KIND_PAYLOAD;
        res.payload_byte = b;
      end
    end
  end

  // State registers; a finished buffer returns to the reset values
  always_ff @(posedge clk) begin
    if (rst || (step && restart)) begin
      byte_index     <= '0;
      crc_acc        <= crcfc_pkg::CRC_INIT;
      start_mismatch <= 1'b0;
      held_seq       <= '0;
      held_msg_id    <= '0;
      held_length    <= '0;
      crc_low_byte   <= '0;
      verdict_given  <= 1'b0;
    end else if (step && !verdict_given) begin
      byte_index     <= byte_index_next;
      crc_acc        <= crc_acc_next;
      start_mismatch <= start_mismatch_next;
      held_seq       <= held_seq_next;
      held_msg_id    <= held_msg_id_next;
      held_length    <= held_length_next;
      crc_low_byte   <= crc_low_byte_next;
      verdict_given  <= verdict_given_next;
    end
  end

endmodule

FILE: test/crc16_frame_checker_tb.sv
// ----------------------------------------------------------------------------
// crc16_frame_checker_tb - self-checking bench for the CRC-16 frame checker
// Feeds whole raw buffers (good frames, bad starts, bad CRCs, oversize and
// truncated frames, noise) and checks every result beat, in order and field
// by field, against a cycle-free model of the deframer. Register settings
// change between phases while the block is drained.
// ----------------------------------------------------------------------------
module crc16_frame_checker_tb;
  import crcfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 10;
  localparam int SEG_ITEMS   = 130;

  // Deframer model plus the queue of result beats it still owes
  class frame_scoreboard;
    cfg_t        regs;
    bit   [16:0] byte_count;
    bit   [15:0] crc_run;
    bit          start_bad;
    bit   [7:0]  seq_hold;
    bit   [7:0]  id_hold;
    bit   [15:0] len_hold;
    bit   [7:0]  crc_lo_hold;
    bit          verdict_sent;
    result_t     due_beats[$];
    int          errors;

    function new();
      regs.start_first   = START_FIRST_RST;
      regs.start_second  = START_SECOND_RST;
      regs.payload_limit = PAYLOAD_LIM_RST;
      errors = 0;
      restart();
    endfunction

    function void restart();
      byte_count   = '0;
      crc_run      = CRC_INIT;
      start_bad    = 1'b0;
      seq_hold     = '0;
      id_hold      = '0;
      len_hold     = '0;
      crc_lo_hold  = '0;
      verdict_sent = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_START_FIRST:  regs.start_first   = data[7:0];
        REG_START_SECOND: regs.start_second  = data[7:0];
        REG_PAYLOAD_LIM:  regs.payload_limit = data;
        default: ;
      endcase
    endfunction

    // Bit-serial CRC-16/CCITT-FALSE over one byte, MSB first
    static function bit [15:0] crc_step(bit [15:0] c, bit [7:0] d);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    // Accepted input beat; returns 0 when the beat is ignored after a verdict
    function bit take_byte(bit [7:0] b, bit last);
      int unsigned idx;
      int unsigned len;
      bit          has_v;
      logic [1:0]  vcode;
      result_t     r;
      idx   = byte_count;
      has_v = 1'b0;
      vcode = VERDICT_OK;
      r     = '0;
      if (verdict_sent) begin
        if (last) restart();
        return 1'b0;
      end
      // header capture
      if (idx == IDX_START0 && b != regs.start_first)  start_bad = 1'b1;
      if (idx == IDX_START1 && b != regs.start_second) start_bad = 1'b1;
      if (idx == IDX_SEQ)    seq_hold = b;
      if (idx == IDX_MSGID)  id_hold  = b;
      if (idx == IDX_LEN_LO) len_hold = {8'h00, b};
      if (idx == IDX_LEN_HI) len_hold = {b, len_hold[7:0]};
      len = len_hold;
      // running CRC and its low byte
      if (idx < IDX_PAYLD || idx < IDX_PAYLD + len) crc_run = crc_step(crc_run, b);
      if (idx >= IDX_PAYLD && idx == IDX_PAYLD + len) crc_lo_hold = b;
      // verdict decision
      if (idx == IDX_CHECK && start_bad) begin
        has_v = 1'b1;
        vcode = VERDICT_CORRUPTED;
      end else if (idx == IDX_CHECK && len > regs.payload_limit) begin
        has_v = 1'b1;
        vcode = VERDICT_TOO_LONG;
      end else if (idx >= IDX_CHECK && idx == IDX_CHECK + len) begin
        has_v = 1'b1;
        vcode = (crc_run == {b, crc_lo_hold}) ? VERDICT_OK : VERDICT_CORRUPTED;
      end
      if (!has_v && last) begin
        has_v = 1'b1;
        vcode = VERDICT_INCOMPLETE;
      end
      if (has_v) begin
        r.result_kind = KIND_VERDICT;
        r.verdict     = vcode;
        if (vcode == VERDICT_OK) begin
          r.frame_seq    = seq_hold;
          r.frame_msg_id = id_hold;
          r.frame_length = len_hold;
        end
        due_beats.push_back(r);
        if (last) restart();
        else verdict_sent = 1'b1;
        return 1'b1;
      end
      if (byte_count != INDEX_MAX) byte_count++;
      // payload pass-through under a clean header
      if (idx >= IDX_PAYLD && idx < IDX_PAYLD + len && !start_bad &&
          len <= regs.payload_limit) begin
        r.result_kind  = KIND_PAYLOAD;
        r.payload_byte = b;
        due_beats.push_back(r);
      end
      return 1'b1;
    endfunction

    // Output beat against the oldest owed beat
    function void check_result(result_t got);
      result_t want;
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d byte %0h verdict %0d",
               got.result_kind, got.payload_byte, got.verdict);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        errors++;
      end
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
        errors++;
      end
      if (got.frame_seq !== want.frame_seq) begin
        $error("frame_seq: expected %0h, got %0h", want.frame_seq, got.frame_seq);
        errors++;
      end
      if (got.frame_msg_id !== want.frame_msg_id) begin
        $error("frame_msg_id: expected %0h, got %0h", want.frame_msg_id, got.frame_msg_id);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
        errors++;
      end
    endfunction
  endclass

  // DUT signals
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte      = '0;
  logic        buffer_end   = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [1:0]  verdict;
  logic [7:0]  frame_seq;
  logic [7:0]  frame_msg_id;
  logic [15:0] frame_length;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;

  // Bench state
  frame_scoreboard sb;
  bit [7:0] frame_bytes[$];
  int       tx_idle_pct  = 0;
  int       rx_idle_pct  = 0;
  bit       hold_request = 1'b0;
  int       hold_left    = 0;
  int       sent_total   = 0;
  int       cycle_count  = 0;

  crc16_frame_checker DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .buffer_end   (buffer_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .verdict      (verdict),
    .frame_seq    (frame_seq),
    .frame_msg_id (frame_msg_id),
    .frame_length (frame_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Output monitor
  always @(posedge clk) begin : watch_out
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got.result_kind  = result_kind;
      got.payload_byte = payload_byte;
      got.verdict      = verdict;
      got.frame_seq    = frame_seq;
      got.frame_msg_id = frame_msg_id;
      got.frame_length = frame_length;
      sb.check_result(got);
    end
  end

  // One input beat; entered and left at a falling edge
  task automatic send_beat(bit [7:0] b, bit last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= b;
    buffer_end <= last;
    do @(posedge clk); while (!in_ready);
    void'(sb.take_byte(b, last));
    sent_total++;
    @(negedge clk);
  endtask

  task automatic send_buffer();
    foreach (frame_bytes[i]) send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Let every owed beat arrive, then allow for bytes still in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(bit [7:0] s0, bit [7:0] s1, bit [15:0] lim);
    write_reg(REG_START_FIRST, {8'h00, s0});
    write_reg(REG_START_SECOND, {8'h00, s1});
    write_reg(REG_PAYLOAD_LIM, lim);
    cfg_valid <= 1'b0;
  endtask

  function automatic void append_crc();
    bit [15:0] c;
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = frame_scoreboard::crc_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endfunction

  // Build one raw buffer; long_open gives a max-length header cut short
  function automatic void make_buffer(bit long_open);
    int pick;
    int lim;
    int len;
    int n;
    int pos;
    bit too_long;
    frame_bytes.delete();
    pick = $urandom_range(0, 99);
    lim  = sb.regs.payload_limit;
    if (long_open) begin
      len = 16'hFFFF;
    end else if (pick < 8) begin
      // noise buffer
      n = $urandom_range(1, 20);
      repeat (n) frame_bytes.push_back(8'($urandom));
      return;
    end
    too_long = !long_open && pick < 16 && lim < 65535;
    if (too_long) begin
      len = $urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 65535);
    end else if (!long_open) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, lim < 300 ? lim : 300);
      else len = $urandom_range(0, lim < 12 ? lim : 12);
    end
    frame_bytes.push_back(sb.regs.start_first);
    frame_bytes.push_back(sb.regs.start_second);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    if (long_open) begin
      repeat (20) frame_bytes.push_back(8'($urandom));
      return;
    end
    if (too_long) begin
      repeat (2) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat (len) frame_bytes.push_back(8'($urandom));
      append_crc();
    end
    // damage, truncation or trailing bytes after the frame
    if (pick >= 16 && pick < 23) begin
      pos = $urandom_range(0, 1);
      frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
    end else if (pick >= 23 && pick < 30) begin
      pos = $urandom_range(2, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end else if (pick >= 30 && pick < 40) begin
      n = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
    end else begin
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
    end
  endfunction

  initial begin : stimulus
    int target;
    sb = new();
    tx_idle_pct = 11;
    rx_idle_pct = 62;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero-length good frame, bad start with a byte after the
    // verdict, one-byte buffer, maximum declared length
    frame_bytes = '{START_FIRST_RST, START_SECOND_RST, 8'h00, 8'h00, 8'h00, 8'h00};
    append_crc();
    send_buffer();
    frame_bytes = '{8'h00, START_SECOND_RST, 8'hFF, 8'hFF, 8'h00, 8'h00,
                    8'h11, 8'h22, 8'hFF};
    send_buffer();
    frame_bytes = '{8'hFF};
    send_buffer();
    frame_bytes = '{START_FIRST_RST, START_SECOND_RST, 8'h12, 8'h34, 8'hFF, 8'hFF,
                    8'h00, 8'h00};
    send_buffer();

    // Random phases: settings and idling change between them
    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 62 : 0;
      rx_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 11 : 0;
      if (seg > 0) wait_drained();
      case (seg)
        1: set_config(8'h00, 8'hFF, 16'd0);
        2: set_config(8'hFF, 8'h00, 16'hFFFF);
        3: set_config(8'($urandom), 8'($urandom), 16'($urandom_range(0, 20)));
        4: set_config(START_FIRST_RST, START_SECOND_RST, 16'd7);
        5: set_config(8'($urandom), 8'($urandom), 16'd300);
        default: ;
      endcase
      if (seg == 2) begin
        make_buffer(1'b1);
        send_buffer();
      end
      // output stalls for a long stretch while bytes keep coming
      if (seg == 4) hold_request = 1'b1;
      target = sent_total + SEG_ITEMS;
      while (sent_total < target) begin
        make_buffer(1'b0);
        send_buffer();
      end
    end

    wait_drained();
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
